// ===== sv/edfd_pkg.sv =====
package edfd_pkg;

   localparam int unsigned MAX_TAGS = 2;
   localparam int unsigned TAG_W = (MAX_TAGS > 2) ? 3 : 2;

   localparam int unsigned POS_W = 7;
   localparam int unsigned START_W = 5;
   localparam int unsigned LEN_W = POS_W + 1;

   localparam logic [POS_W-1:0] POS_MAX = 7'd127;

   localparam logic [START_W-1:0] ETH_HDR_LEN = 5'd14;
   localparam logic [START_W-1:0] TAG_LEN = 5'd4;
   localparam logic [LEN_W-1:0] IPV4_MIN_TAIL = 8'd28;
   localparam logic [LEN_W-1:0] IPV6_MIN_TAIL = 8'd48;

   localparam logic [15:0] ETYPE_VLAN = 16'h8100;
   localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] MF_AND_OFFSET_HI = 8'h3F;
   localparam logic [7:0] HOST_BROADCAST = 8'd255;
   localparam logic [7:0] HOST_NETWORK = 8'd0;

   localparam logic [POS_W-1:0] V4_FRAG_HI_OFS = 7'd6;
   localparam logic [POS_W-1:0] V4_FRAG_LO_OFS = 7'd7;
   localparam logic [POS_W-1:0] V4_PROTO_OFS = 7'd9;
   localparam logic [POS_W-1:0] V4_HOST_OFS = 7'd19;
   localparam logic [POS_W-1:0] V4_UDP_OFS = 7'd20;
   localparam logic [POS_W-1:0] V6_NEXT_OFS = 7'd6;
   localparam logic [POS_W-1:0] V6_UDP_OFS = 7'd40;

   localparam logic [15:0] BLOCKED_PORT_RESET = 16'd53;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_V4    = 2'd1,
      KIND_V6    = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } byte_event_type;

endpackage

// ===== sv/ethernet_dns_fragment_drop_filter.sv =====
// Frame filter taking one byte per cycle. Each byte transfer goes into an input
// register, is parsed against the frame state from there, and on the final byte
// the pass/drop verdict lands in the result register. The block sustains one
// byte per cycle; bytes that are not final keep flowing while a verdict waits
// to be taken, and only a final byte stalls behind an untaken verdict. Write
// csr_wr_data with csr_wr_en while no frame is in flight; the blocked port
// resets to 53.
module ethernet_dns_fragment_drop_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_drop,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import edfd_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_drop_ff;
   logic [15:0]    blocked_port_ff;
   logic           out_free;
   logic           take;
   logic           verdict;
   byte_event_type ev;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign take        = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall   = in_valid_ff && !take;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      priority if (take && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign ev = '{valid: take, data: in_byte_ff, last: in_last_ff};

   edfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .ev           (ev),
      .blocked_port (blocked_port_ff),
      .drop         (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         blocked_port_ff <= BLOCKED_PORT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) blocked_port_ff <= csr_wr_data;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_packet_byte;
         in_last_ff <= req_last_byte;
      end
      if (take && in_last_ff) rsp_drop_ff <= verdict;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drop  = rsp_drop_ff;

endmodule

// ===== sv/edfd_parser.sv =====
module edfd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  edfd_pkg::byte_event_type ev,
   input  logic [15:0]             blocked_port,
   output logic                    drop
);
   import edfd_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        etype_ff, etype_in;
   logic [TAG_W-1:0]   tags_ff, tags_in;
   kind_type           kind_ff, kind_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [7:0]         host_ff, host_in;
   logic               frag_ff, frag_in;
   logic [7:0]         proto_ff, proto_in;
   logic [15:0]        sport_ff, sport_in;
   logic [15:0]        dport_ff, dport_in;

   logic [POS_W-1:0]   rel;
   logic [POS_W-1:0]   udp_base;
   logic [LEN_W-1:0]   len;
   logic               port_hit;

   // next frame state for this byte
   always_comb begin
      etype_in = {etype_ff[7:0], ev.data};
      tags_in  = tags_ff;
      kind_in  = kind_ff;
      start_in = start_ff;
      host_in  = host_ff;
      frag_in  = frag_ff;
      proto_in = proto_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      rel      = pos_ff - POS_W'(start_ff);
      udp_base = (kind_ff == KIND_V4) ? V4_UDP_OFS : V6_UDP_OFS;

      if (kind_ff == KIND_NONE) begin
         if (({1'b0, pos_ff} + LEN_W'(1)) == LEN_W'(start_ff)) begin
            priority if (((etype_in == ETYPE_VLAN) || (etype_in == ETYPE_QINQ))
                         && (tags_ff < TAG_W'(MAX_TAGS))) begin
               tags_in  = tags_ff + TAG_W'(1);
               start_in = start_ff + TAG_LEN;
            end else if (etype_in == ETYPE_IPV4) begin
               kind_in = KIND_V4;
            end else if (etype_in == ETYPE_IPV6) begin
               kind_in = KIND_V6;
            end else begin
               kind_in = KIND_OTHER;
            end
         end
      end else if (pos_ff >= POS_W'(start_ff)) begin
         if (kind_ff == KIND_V4) begin
            if (rel == V4_FRAG_HI_OFS) frag_in = |(ev.data & MF_AND_OFFSET_HI);
            if (rel == V4_FRAG_LO_OFS) frag_in = frag_ff | (|ev.data);
            if (rel == V4_PROTO_OFS)   proto_in = ev.data;
            if (rel == V4_HOST_OFS)    host_in = ev.data;
         end
         if ((kind_ff == KIND_V6) && (rel == V6_NEXT_OFS)) proto_in = ev.data;
         if ((kind_ff == KIND_V4) || (kind_ff == KIND_V6)) begin
            if (rel == udp_base)               sport_in = {ev.data, sport_ff[7:0]};
            if (rel == udp_base + POS_W'(1))   sport_in = {sport_ff[15:8], ev.data};
            if (rel == udp_base + POS_W'(2))   dport_in = {ev.data, dport_ff[7:0]};
            if (rel == udp_base + POS_W'(3))   dport_in = {dport_ff[15:8], ev.data};
         end
      end
   end

   // verdict on the state after this byte
   always_comb begin
      len      = {1'b0, pos_ff} + LEN_W'(1);
      port_hit = (proto_in == PROTO_UDP) &&
                 ((sport_in == blocked_port) || (dport_in == blocked_port));
      drop     = 1'b0;
      unique case (kind_in)
         KIND_V4: begin
            if (len >= LEN_W'(start_in) + IPV4_MIN_TAIL) begin
               drop = (host_in == HOST_NETWORK) || (host_in == HOST_BROADCAST) ||
                      frag_in || port_hit;
            end
         end
         KIND_V6: begin
            if (len >= LEN_W'(start_in) + IPV6_MIN_TAIL) begin
               drop = port_hit;
            end
         end
         default: drop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (ev.valid && ev.last)) begin
         pos_ff   <= '0;
         etype_ff <= '0;
         tags_ff  <= '0;
         kind_ff  <= KIND_NONE;
         start_ff <= ETH_HDR_LEN;
         host_ff  <= '0;
         frag_ff  <= 1'b0;
         proto_ff <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
      end else if (ev.valid) begin
         pos_ff   <= pos_in;
         etype_ff <= etype_in;
         tags_ff  <= tags_in;
         kind_ff  <= kind_in;
         start_ff <= start_in;
         host_ff  <= host_in;
         frag_ff  <= frag_in;
         proto_ff <= proto_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
      end
   end

   assign pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;

endmodule

// ===== sv/edfd_checker.sv =====
module edfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_drop
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall left after reset");

   a_stall_only_behind_verdict: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting verdict");

   a_verdict_from_final_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte, 2))
      else $error("verdict without a final byte transfer");

   a_verdict_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drop))
      else $error("stalled verdict changed");

endmodule

bind ethernet_dns_fragment_drop_filter edfd_checker u_edfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_drop      (rsp_drop)
);
